[sv/cpor_pkg.sv]
`timescale 1ns / 1ps

package cpor_pkg;

   localparam int COORD_W   = 24;
   localparam int RAD_W     = 16;
   localparam int WDIFF_W   = 25;                 // full-range centre difference
   localparam int DIFF_W    = 18;                 // difference once overlap is known
   localparam int MAG_W     = DIFF_W - 1;
   localparam int SUM_W     = RAD_W + 1;
   localparam int SQ_W      = 2 * WDIFF_W;
   localparam int D2_W      = 2 * SUM_W;          // d2 < sum^2 whenever it matters
   localparam int ROOT_W    = D2_W / 2;
   localparam int SQ_STEPS  = ROOT_W;
   localparam int SQ_REM_W  = ROOT_W + 2;
   localparam int DEPTH_W   = SUM_W + 2;          // 3 * (sum - dist)
   localparam int PROD_W    = MAG_W + RAD_W;
   localparam int DEN0_W    = 2 * SUM_W;
   localparam int DEN_W     = DEN0_W + 3;
   localparam int NUM_W     = PROD_W + DEPTH_W;
   localparam int QUOT_W    = 17;                 // |move| < 3/4 of the radius sum
   localparam int MOVE_W    = QUOT_W + 2;
   localparam int WIDE_W    = COORD_W + 2;

   typedef struct packed {
      logic signed [COORD_W-1:0] first_x;
      logic signed [COORD_W-1:0] first_y;
      logic        [RAD_W-1:0]   first_radius;
      logic signed [COORD_W-1:0] second_x;
      logic signed [COORD_W-1:0] second_y;
      logic        [RAD_W-1:0]   second_radius;
   } req_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] new_first_x;
      logic signed [COORD_W-1:0] new_first_y;
      logic signed [COORD_W-1:0] new_second_x;
      logic signed [COORD_W-1:0] new_second_y;
      logic                      overlapped;
   } rsp_type;

   // classified pair handed from the front end to the back end
   typedef struct packed {
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] by;
      logic        [RAD_W-1:0]   ar;
      logic        [RAD_W-1:0]   br;
      logic signed [DIFF_W-1:0]  dx;
      logic signed [DIFF_W-1:0]  dy;
      logic        [SUM_W-1:0]   sum;
      logic        [D2_W-1:0]    d2;
      logic                      hit;
   } entry_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] ax;
      logic signed [COORD_W-1:0] ay;
      logic signed [COORD_W-1:0] bx;
      logic signed [COORD_W-1:0] by;
      logic                      hit;
      logic                      moved;
      logic                      sx;
      logic                      sy;
   } side_type;

   // floored signed move from an unsigned quotient and remainder flag
   function automatic logic signed [MOVE_W-1:0] move_of(
      input logic [QUOT_W-1:0] q,
      input logic              nz,
      input logic              neg
   );
      logic [MOVE_W-1:0] mag;
      logic [MOVE_W-1:0] base;
      base = {2'b00, q};
      mag  = neg ? (base + {{(MOVE_W-1){1'b0}}, nz}) : base;
      return neg ? $signed(-mag) : $signed(mag);
   endfunction

   function automatic logic signed [COORD_W-1:0] sat24(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = WIDE_W'(signed'({1'b0, {(COORD_W-1){1'b1}}}));
      lo = -hi - WIDE_W'(1);
      if (v > hi) begin
         return hi[COORD_W-1:0];
      end else if (v < lo) begin
         return lo[COORD_W-1:0];
      end
      return v[COORD_W-1:0];
   endfunction

endpackage

[sv/cpor_front.sv]
`timescale 1ns / 1ps

module cpor_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  cpor_pkg::req_type   req_data,
   output logic                push,
   output cpor_pkg::entry_type push_data,
   input  logic                q_full
);
   import cpor_pkg::*;

   logic                      en;
   logic                      f1_valid_ff, f2_valid_ff, f3_valid_ff;
   req_type                   f1_req_ff, f2_req_ff;
   logic signed [WDIFF_W-1:0] f1_dx_ff, f1_dy_ff, f2_dx_ff, f2_dy_ff;
   logic signed [WDIFF_W-1:0] dx_in, dy_in;
   logic [SUM_W-1:0]          f1_sum_ff, f2_sum_ff;
   logic signed [SQ_W-1:0]    dx_ext, dy_ext;
   logic [SQ_W-1:0]           f2_sqx_ff, f2_sqy_ff, sqx_in, sqy_in;
   logic [D2_W-1:0]           sum_ext, f2_sum2_ff, sum2_in;
   logic [SQ_W:0]             d2_in;
   entry_type                 f3_ff, f3_in;

   assign en        = !f3_valid_ff || !q_full;
   assign req_ready = en;
   assign push      = f3_valid_ff && !q_full;
   assign push_data = f3_ff;

   // stage 1: differences and radius sum
   assign dx_in = WDIFF_W'(req_data.first_x) - WDIFF_W'(req_data.second_x);
   assign dy_in = WDIFF_W'(req_data.first_y) - WDIFF_W'(req_data.second_y);

   // stage 2: squares
   assign dx_ext  = SQ_W'(f1_dx_ff);
   assign dy_ext  = SQ_W'(f1_dy_ff);
   assign sqx_in  = dx_ext * dx_ext;
   assign sqy_in  = dy_ext * dy_ext;
   assign sum_ext = D2_W'(f1_sum_ff);
   assign sum2_in = sum_ext * sum_ext;

   // stage 3: distance compare
   always_comb begin
      d2_in        = {1'b0, f2_sqx_ff} + {1'b0, f2_sqy_ff};
      f3_in.ax     = f2_req_ff.first_x;
      f3_in.ay     = f2_req_ff.first_y;
      f3_in.bx     = f2_req_ff.second_x;
      f3_in.by     = f2_req_ff.second_y;
      f3_in.ar     = f2_req_ff.first_radius;
      f3_in.br     = f2_req_ff.second_radius;
      f3_in.dx     = f2_dx_ff[DIFF_W-1:0];
      f3_in.dy     = f2_dy_ff[DIFF_W-1:0];
      f3_in.sum    = f2_sum_ff;
      f3_in.d2     = d2_in[D2_W-1:0];
      f3_in.hit    = d2_in < (SQ_W+1)'(f2_sum2_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
         f3_valid_ff <= 1'b0;
      end else if (en) begin
         f1_valid_ff <= req_valid;
         f2_valid_ff <= f1_valid_ff;
         f3_valid_ff <= f2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         f1_req_ff  <= req_data;
         f1_dx_ff   <= dx_in;
         f1_dy_ff   <= dy_in;
         f1_sum_ff  <= SUM_W'(req_data.first_radius) + SUM_W'(req_data.second_radius);
         f2_req_ff  <= f1_req_ff;
         f2_dx_ff   <= f1_dx_ff;
         f2_dy_ff   <= f1_dy_ff;
         f2_sum_ff  <= f1_sum_ff;
         f2_sqx_ff  <= sqx_in;
         f2_sqy_ff  <= sqy_in;
         f2_sum2_ff <= sum2_in;
         f3_ff      <= f3_in;
      end
   end

endmodule

[sv/cpor_queue.sv]
`timescale 1ns / 1ps

module cpor_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  cpor_pkg::entry_type push_data,
   input  logic                pop,
   output cpor_pkg::entry_type head,
   output logic                full,
   output logic                empty
);
   import cpor_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push, do_pop;

   assign full    = count_ff == CNT_W'(DEPTH);
   assign empty   = count_ff == '0;
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

[sv/cpor_div.sv]
`timescale 1ns / 1ps

module cpor_div (
   input  logic                         clock,
   input  logic                         en,
   input  logic [cpor_pkg::NUM_W-1:0]   num,
   input  logic [cpor_pkg::DEN_W-1:0]   den,
   output logic [cpor_pkg::QUOT_W-1:0]  quot,
   output logic                         rem_nz
);
   import cpor_pkg::*;

   localparam int CMP_W = DEN_W + QUOT_W;

   logic [NUM_W-1:0]  rem_ff  [1:QUOT_W];
   logic [QUOT_W-1:0] quot_ff [1:QUOT_W];
   logic [DEN_W-1:0]  den_ff  [1:QUOT_W];

   // restoring division, one quotient bit per stage, msb first
   for (genvar k = 1; k <= QUOT_W; k++) begin : g_step
      logic [NUM_W-1:0]  p_rem;
      logic [QUOT_W-1:0] p_quot;
      logic [DEN_W-1:0]  p_den;
      logic [CMP_W-1:0]  rem_ext, sh;
      logic              ge;

      if (k == 1) begin : g_first
         assign p_rem  = num;
         assign p_quot = '0;
         assign p_den  = den;
      end else begin : g_next
         assign p_rem  = rem_ff[k-1];
         assign p_quot = quot_ff[k-1];
         assign p_den  = den_ff[k-1];
      end

      assign rem_ext = CMP_W'(p_rem);
      assign sh      = CMP_W'(p_den) << (QUOT_W - k);
      assign ge      = rem_ext >= sh;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= ge ? NUM_W'(rem_ext - sh) : p_rem;
            quot_ff[k] <= {p_quot[QUOT_W-2:0], ge};
            den_ff[k]  <= p_den;
         end
      end
   end

   assign quot   = quot_ff[QUOT_W];
   assign rem_nz = |rem_ff[QUOT_W];

endmodule

[sv/cpor_back.sv]
`timescale 1ns / 1ps

module cpor_back (
   input  logic                clock,
   input  logic                reset,
   input  cpor_pkg::entry_type head,
   input  logic                q_empty,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output cpor_pkg::rsp_type   rsp_data
);
   import cpor_pkg::*;

   logic en;

   // square root pipeline
   entry_type           sq_ent_ff   [1:SQ_STEPS];
   logic [ROOT_W-1:0]   sq_root_ff  [1:SQ_STEPS];
   logic [SQ_REM_W-1:0] sq_rem_ff   [1:SQ_STEPS];
   logic                sq_valid_ff [1:SQ_STEPS];

   // product stages
   entry_type           tail;
   logic [ROOT_W-1:0]   root_dist;
   logic [DIFF_W-1:0]   ndx, ndy;
   logic [MAG_W-1:0]    adx, ady;
   logic [DEPTH_W-1:0]  depth, depth3_in;
   logic [DEN0_W-1:0]   sum_e, dist_e;
   logic [PROD_W-1:0]   adx_e, ady_e, ar_e, br_e;
   side_type            side_in;
   side_type            m1_side_ff, m2_side_ff;
   logic                m1_valid_ff, m2_valid_ff;
   logic [DEPTH_W-1:0]  m1_depth3_ff;
   logic [DEN0_W-1:0]   m1_den0_ff;
   logic [PROD_W-1:0]   m1_pxb_ff, m1_pyb_ff, m1_pxa_ff, m1_pya_ff;
   logic [NUM_W-1:0]    d3_e;
   logic [NUM_W-1:0]    m2_nxb_ff, m2_nyb_ff, m2_nxa_ff, m2_nya_ff;
   logic [DEN_W-1:0]    m2_den_ff;

   // divider alignment
   side_type            dv_side_ff  [1:QUOT_W];
   logic                dv_valid_ff [1:QUOT_W];
   logic [QUOT_W-1:0]   q_xb, q_yb, q_xa, q_ya;
   logic                nz_xb, nz_yb, nz_xa, nz_ya;

   // result
   side_type                  fin;
   logic signed [MOVE_W-1:0]  mv_ax, mv_ay, mv_bx, mv_by;
   logic signed [WIDE_W-1:0]  wax, way, wbx, wby;
   rsp_type                   rsp_in, rsp_data_ff;
   logic                      rsp_valid_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign pop       = en && !q_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // integer square root, one result bit per stage
   for (genvar k = 1; k <= SQ_STEPS; k++) begin : g_sq
      entry_type           p_ent;
      logic [ROOT_W-1:0]   p_root;
      logic [SQ_REM_W-1:0] p_rem;
      logic                p_valid;
      logic [SQ_REM_W+1:0] cand, trial;

      if (k == 1) begin : g_first
         assign p_ent   = head;
         assign p_root  = '0;
         assign p_rem   = '0;
         assign p_valid = !q_empty;
      end else begin : g_next
         assign p_ent   = sq_ent_ff[k-1];
         assign p_root  = sq_root_ff[k-1];
         assign p_rem   = sq_rem_ff[k-1];
         assign p_valid = sq_valid_ff[k-1];
      end

      assign cand  = {p_rem, p_ent.d2[2*(SQ_STEPS-k)+1 -: 2]};
      assign trial = {{(SQ_REM_W-ROOT_W){1'b0}}, p_root, 2'b01};

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k] <= 1'b0;
         end else if (en) begin
            sq_valid_ff[k] <= p_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sq_ent_ff[k] <= p_ent;
            if (cand >= trial) begin
               sq_rem_ff[k]  <= SQ_REM_W'(cand - trial);
               sq_root_ff[k] <= {p_root[ROOT_W-2:0], 1'b1};
            end else begin
               sq_rem_ff[k]  <= SQ_REM_W'(cand);
               sq_root_ff[k] <= {p_root[ROOT_W-2:0], 1'b0};
            end
         end
      end
   end

   // first product stage
   always_comb begin
      tail      = sq_ent_ff[SQ_STEPS];
      root_dist = sq_root_ff[SQ_STEPS];
      ndx       = -tail.dx;
      ndy       = -tail.dy;
      adx       = tail.dx[DIFF_W-1] ? ndx[MAG_W-1:0] : tail.dx[MAG_W-1:0];
      ady       = tail.dy[DIFF_W-1] ? ndy[MAG_W-1:0] : tail.dy[MAG_W-1:0];
      depth     = DEPTH_W'(tail.sum) - DEPTH_W'(root_dist);
      depth3_in = (depth << 1) + depth;
      sum_e     = DEN0_W'(tail.sum);
      dist_e    = DEN0_W'(root_dist);
      adx_e     = PROD_W'(adx);
      ady_e     = PROD_W'(ady);
      ar_e      = PROD_W'(tail.ar);
      br_e      = PROD_W'(tail.br);
      side_in.ax    = tail.ax;
      side_in.ay    = tail.ay;
      side_in.bx    = tail.bx;
      side_in.by    = tail.by;
      side_in.hit   = tail.hit;
      side_in.moved = tail.hit && (root_dist != '0);
      side_in.sx    = tail.dx[DIFF_W-1];
      side_in.sy    = tail.dy[DIFF_W-1];
   end

   assign d3_e = NUM_W'(m1_depth3_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         m1_valid_ff <= 1'b0;
         m2_valid_ff <= 1'b0;
      end else if (en) begin
         m1_valid_ff <= sq_valid_ff[SQ_STEPS];
         m2_valid_ff <= m1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m1_side_ff   <= side_in;
         m1_depth3_ff <= depth3_in;
         m1_den0_ff   <= sum_e * dist_e;
         m1_pxb_ff    <= adx_e * br_e;
         m1_pyb_ff    <= ady_e * br_e;
         m1_pxa_ff    <= adx_e * ar_e;
         m1_pya_ff    <= ady_e * ar_e;
         m2_side_ff   <= m1_side_ff;
         m2_nxb_ff    <= NUM_W'(m1_pxb_ff) * d3_e;
         m2_nyb_ff    <= NUM_W'(m1_pyb_ff) * d3_e;
         m2_nxa_ff    <= NUM_W'(m1_pxa_ff) * d3_e;
         m2_nya_ff    <= NUM_W'(m1_pya_ff) * d3_e;
         m2_den_ff    <= {m1_den0_ff, 3'b000};
      end
   end

   cpor_div u_div_xb (.clock, .en, .num(m2_nxb_ff), .den(m2_den_ff),
                      .quot(q_xb), .rem_nz(nz_xb));
   cpor_div u_div_yb (.clock, .en, .num(m2_nyb_ff), .den(m2_den_ff),
                      .quot(q_yb), .rem_nz(nz_yb));
   cpor_div u_div_xa (.clock, .en, .num(m2_nxa_ff), .den(m2_den_ff),
                      .quot(q_xa), .rem_nz(nz_xa));
   cpor_div u_div_ya (.clock, .en, .num(m2_nya_ff), .den(m2_den_ff),
                      .quot(q_ya), .rem_nz(nz_ya));

   // sideband follows the dividers
   for (genvar k = 1; k <= QUOT_W; k++) begin : g_dly
      side_type p_side;
      logic     p_valid;

      if (k == 1) begin : g_first
         assign p_side  = m2_side_ff;
         assign p_valid = m2_valid_ff;
      end else begin : g_next
         assign p_side  = dv_side_ff[k-1];
         assign p_valid = dv_valid_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[k] <= 1'b0;
         end else if (en) begin
            dv_valid_ff[k] <= p_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dv_side_ff[k] <= p_side;
         end
      end
   end

   // apply moves and saturate
   always_comb begin
      fin   = dv_side_ff[QUOT_W];
      mv_ax = fin.moved ? move_of(q_xb, nz_xb, fin.sx) : '0;
      mv_ay = fin.moved ? move_of(q_yb, nz_yb, fin.sy) : '0;
      mv_bx = fin.moved ? move_of(q_xa, nz_xa, fin.sx) : '0;
      mv_by = fin.moved ? move_of(q_ya, nz_ya, fin.sy) : '0;
      wax   = WIDE_W'(fin.ax) + WIDE_W'(mv_ax);
      way   = WIDE_W'(fin.ay) + WIDE_W'(mv_ay);
      wbx   = WIDE_W'(fin.bx) - WIDE_W'(mv_bx);
      wby   = WIDE_W'(fin.by) - WIDE_W'(mv_by);
      rsp_in.new_first_x  = sat24(wax);
      rsp_in.new_first_y  = sat24(way);
      rsp_in.new_second_x = sat24(wbx);
      rsp_in.new_second_y = sat24(wby);
      rsp_in.overlapped   = fin.hit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid_ff[QUOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_in;
      end
   end

endmodule

[sv/circle_pair_overlap_resolve.sv]
// throughput: one request per cycle, sustained while rsp_ready stays high
// the 17 stage root pipeline and the 17 stage dividers set the latency
// reset: synchronous, active high; clears all valid bits and the queue pointers
`timescale 1ns / 1ps

module circle_pair_overlap_resolve #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  cpor_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output cpor_pkg::rsp_type rsp_data
);
   import cpor_pkg::*;

   entry_type push_data, head;
   logic      push, pop, q_full, q_empty;

   // front end: differences, squares and the overlap test, three stages
   cpor_front u_front (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_data,
      .push,
      .push_data,
      .q_full
   );

   // short queue so the front end keeps taking requests while the back end stalls
   cpor_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock,
      .reset,
      .push,
      .push_data,
      .pop,
      .head,
      .full (q_full),
      .empty(q_empty)
   );

   // back end: root, products, four dividers, saturation and output register
   cpor_back u_back (
      .clock,
      .reset,
      .head,
      .q_empty,
      .pop,
      .rsp_valid,
      .rsp_ready,
      .rsp_data
   );

endmodule

[sv/cpor_checker.sv]
`timescale 1ns / 1ps

module cpor_checker #(
   parameter int QUEUE_DEPTH = 4
) (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input cpor_pkg::rsp_type rsp_data
);
   import cpor_pkg::*;

   // front stages, queue, root, products, dividers, output register
   localparam int CAP   = 3 + QUEUE_DEPTH + SQ_STEPS + 2 + QUOT_W + 1;
   localparam int CNT_W = $clog2(CAP + 2);

   logic [CNT_W-1:0] pending_ff;
   logic             req_go, rsp_go;

   assign req_go = req_valid && req_ready;
   assign rsp_go = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else if (req_go && !rsp_go) begin
         pending_ff <= pending_ff + CNT_W'(1);
      end else if (rsp_go && !req_go) begin
         pending_ff <= pending_ff - CNT_W'(1);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response dropped or changed while stalled");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != '0)
      else $error("response with no request outstanding");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= CNT_W'(CAP))
      else $error("more requests outstanding than the pipeline holds");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind circle_pair_overlap_resolve cpor_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_cpor_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_data (rsp_data)
);

[sim/tb_circle_pair_overlap_resolve.sv]
`timescale 1ns / 1ps

// scoreboard: computes the separated pair for each accepted request
class overlap_scoreboard;
   cpor_pkg::rsp_type pending_q[$];
   int errors;

   function new();
      errors = 0;
   endfunction

   function automatic longint floor_div(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && a < 0) q -= 1;
      return q;
   endfunction

   function automatic longint clamp24(longint v);
      if (v > 8388607) return 8388607;
      if (v < -8388608) return -8388608;
      return v;
   endfunction

   function automatic longint int_sqrt(longint v);
      longint r;
      longint b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function void note_request(cpor_pkg::req_type q);
      cpor_pkg::rsp_type e;
      longint ax, ay, bx, by, ar, br, dx, dy, d2, s, root_dist, depth3, den;
      longint nax, nay, nbx, nby;
      ax = longint'(q.first_x); ay = longint'(q.first_y);
      bx = longint'(q.second_x); by = longint'(q.second_y);
      ar = longint'(q.first_radius); br = longint'(q.second_radius);
      dx = ax - bx; dy = ay - by;
      d2 = dx * dx + dy * dy;
      s = ar + br;
      nax = ax; nay = ay; nbx = bx; nby = by;
      e.overlapped = d2 < s * s;
      if (e.overlapped) begin
         root_dist = int_sqrt(d2);
         if (root_dist > 0) begin
            depth3 = 3 * (s - root_dist);
            den = root_dist * s * 8;
            nax = ax + floor_div(dx * br * depth3, den);
            nay = ay + floor_div(dy * br * depth3, den);
            nbx = bx - floor_div(dx * ar * depth3, den);
            nby = by - floor_div(dy * ar * depth3, den);
         end
      end
      e.new_first_x = cpor_pkg::COORD_W'(clamp24(nax));
      e.new_first_y = cpor_pkg::COORD_W'(clamp24(nay));
      e.new_second_x = cpor_pkg::COORD_W'(clamp24(nbx));
      e.new_second_y = cpor_pkg::COORD_W'(clamp24(nby));
      pending_q.push_back(e);
   endfunction

   function void check_response(cpor_pkg::rsp_type got);
      cpor_pkg::rsp_type e;
      if (pending_q.size() == 0) begin
         $display("%0t: unexpected response %h", $time, got);
         errors++;
         return;
      end
      e = pending_q.pop_front();
      if (got.new_first_x !== e.new_first_x) begin
         $display("%0t: new_first_x exp %0d got %0d", $time, e.new_first_x, got.new_first_x);
         errors++;
      end
      if (got.new_first_y !== e.new_first_y) begin
         $display("%0t: new_first_y exp %0d got %0d", $time, e.new_first_y, got.new_first_y);
         errors++;
      end
      if (got.new_second_x !== e.new_second_x) begin
         $display("%0t: new_second_x exp %0d got %0d", $time, e.new_second_x,
                  got.new_second_x);
         errors++;
      end
      if (got.new_second_y !== e.new_second_y) begin
         $display("%0t: new_second_y exp %0d got %0d", $time, e.new_second_y,
                  got.new_second_y);
         errors++;
      end
      if (got.overlapped !== e.overlapped) begin
         $display("%0t: overlapped exp %0b got %0b", $time, e.overlapped, got.overlapped);
         errors++;
      end
   endfunction
endclass

module tb_circle_pair_overlap_resolve;
   import cpor_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES = 60;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   overlap_scoreboard board = new();
   bit   quiet_phase = 1'b0;   // no idling on either side while set
   int   stall_cycles = 0;

   always #4 clock = ~clock;

   circle_pair_overlap_resolve uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // result side: sample at the edge, then pick the next ready level
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_response(rsp_data);
         rsp_ready <= quiet_phase ? 1'b1 : ($urandom_range(99) >= 25);
      end
   end

   // watchdog: cycles in a row with no handshake on either side
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // present one request and hold it until the handshake
   task automatic send_request(req_type q);
      if (!quiet_phase) begin
         while ($urandom_range(99) < 25) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= q;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(q);
   endtask

   task automatic send_pair(int ax, int ay, int ar, int bx, int by, int br);
      req_type q;
      q.first_x = COORD_W'(ax); q.first_y = COORD_W'(ay); q.first_radius = RAD_W'(ar);
      q.second_x = COORD_W'(bx); q.second_y = COORD_W'(by); q.second_radius = RAD_W'(br);
      send_request(q);
   endtask

   function automatic int rand_coord();
      return int'($signed(24'($urandom())));
   endfunction

   // mostly overlapping pairs: second centre near the first
   task automatic send_random();
      int ax, ay, ar, br, span;
      int pick;
      pick = $urandom_range(99);
      ax = rand_coord(); ay = rand_coord();
      if (pick < 15) begin
         send_pair(ax, ay, $urandom_range(65535), rand_coord(), rand_coord(),
                   $urandom_range(65535));
      end else begin
         ar = (pick < 40) ? $urandom_range(65535) : $urandom_range(2047);
         br = (pick < 40) ? $urandom_range(65535) : $urandom_range(2047);
         span = ar + br + 2;
         send_pair(ax, ay, ar,
                   ax + $signed($urandom_range(2 * span)) - span,
                   ay + $signed($urandom_range(2 * span)) - span, br);
      end
   endtask

   task automatic wait_empty();
      req_valid <= 1'b0;
      while (board.pending_q.size() != 0) @(posedge clock);
   endtask

   initial begin
      int k;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, touching, coincident centres, zero radii, saturation
      send_pair(0, 0, 0, 0, 0, 0);
      send_pair(0, 0, 256, 512, 0, 256);
      send_pair(0, 0, 256, 511, 0, 256);
      send_pair(100, -100, 500, 100, -100, 700);
      send_pair(5, 5, 1, 5, 5, 0);
      send_pair(8388607, 8388607, 65535, 8388600, 8388600, 65535);
      send_pair(-8388608, -8388608, 65535, -8388600, -8388600, 65535);
      send_pair(8388607, -8388608, 65535, -8388608, 8388607, 65535);
      send_pair(-8388608, 8388607, 0, 8388607, -8388608, 0);
      send_pair(0, 0, 65535, 1, 0, 0);
      send_pair(0, 0, 0, 0, 1, 65535);
      send_pair(-3, 7, 1000, 4, -9, 3);
      send_pair(1000, 1000, 65535, -1000, -1000, 65535);
      send_pair(8388607, 0, 65535, 8388606, 0, 65535);
      send_pair(0, -8388608, 40000, 0, -8388607, 40000);
      send_pair(-1, -1, 2, 0, 0, 2);
      send_pair(0, 0, 16'hAAAA, 3, 4, 16'h5555);

      // pause until the pipeline drains
      wait_empty();

      for (k = 0; k < 1000; k++) begin
         quiet_phase = (k >= 400 && k < 550);
         send_random();
      end
      quiet_phase = 1'b0;
      req_valid <= 1'b0;

      while (board.pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
